// ===== sv/lkq_pkg.sv =====
// Shared types, constants and the ladder decode for the keypad qualifier.
package lkq_pkg;

	localparam int ADC_W     = 12;
	localparam int NOW_W     = 64;
	localparam int MODE_W    = 3;
	localparam int KEY_W     = 3;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [KEY_W-1:0] KEY_NONE      = 3'd0;
	localparam logic [KEY_W-1:0] KEY_PAIR      = 3'd1;
	localparam logic [KEY_W-1:0] KEY_MODE_BASE = 3'd2;

	localparam logic [MODE_W-1:0] MODE_COUNT = 3'd5;

	// Ladder thresholds: a code below each bound selects that key
	localparam logic [ADC_W-1:0] THR_PAIR  = 12'd555;
	localparam logic [ADC_W-1:0] THR_KEY2  = 12'd1024;
	localparam logic [ADC_W-1:0] THR_KEY3  = 12'd1679;
	localparam logic [ADC_W-1:0] THR_KEY4  = 12'd2432;
	localparam logic [ADC_W-1:0] THR_KEY5  = 12'd3096;
	localparam logic [ADC_W-1:0] THR_KEY6  = 12'd3735;

	localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 32'd30000;
	localparam logic [CFG_W-1:0] RST_RELEASE_ARM  = 32'd150000;
	localparam logic [CFG_W-1:0] RST_PAIR_HOLD    = 32'd1500000;
	localparam logic [CFG_W-1:0] RST_REBOOT_DELAY = 32'd2500000;
	localparam logic [CFG_W-1:0] RST_BLINK_PERIOD = 32'd120000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE     = 8'd0,
		CFG_RELEASE_ARM  = 8'd1,
		CFG_PAIR_HOLD    = 8'd2,
		CFG_REBOOT_DELAY = 8'd3,
		CFG_BLINK_PERIOD = 8'd4
	} lkq_cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] release_arm_time;
		logic [CFG_W-1:0] pair_hold_time;
		logic [CFG_W-1:0] reboot_delay_time;
		logic [CFG_W-1:0] blink_period;
	} lkq_cfg_t;

	function automatic logic [KEY_W-1:0] lkq_decode(input logic [ADC_W-1:0] s);
		logic [KEY_W-1:0] k;
		if (s < THR_PAIR)      k = KEY_PAIR;
		else if (s < THR_KEY2) k = 3'd2;
		else if (s < THR_KEY3) k = 3'd3;
		else if (s < THR_KEY4) k = 3'd4;
		else if (s < THR_KEY5) k = 3'd5;
		else if (s < THR_KEY6) k = 3'd6;
		else                   k = KEY_NONE;
		return k;
	endfunction

endpackage

// ===== sv/lkq_if.sv =====
// Channel interfaces: ladder samples in, qualified results out, register writes.
interface lkq_in_if import lkq_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ADC_W-1:0]  adc_sample;
	logic [NOW_W-1:0]  now_us;
	logic [MODE_W-1:0] current_mode;

	modport source (output valid, output adc_sample, output now_us, output current_mode,
		input ready);
	modport sink (input valid, input adc_sample, input now_us, input current_mode,
		output ready);
	modport mon (input valid, input ready, input adc_sample, input now_us, input current_mode);
endinterface

interface lkq_out_if import lkq_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  stable_key;
	logic              mode_request_valid;
	logic [MODE_W-1:0] mode_request;
	logic              pair_event;
	logic              reboot_request;
	logic              led_on;
	logic              input_armed;

	modport source (output valid, output stable_key, output mode_request_valid,
		output mode_request, output pair_event, output reboot_request, output led_on,
		output input_armed, input ready);
	modport sink (input valid, input stable_key, input mode_request_valid,
		input mode_request, input pair_event, input reboot_request, input led_on,
		input input_armed, output ready);
	modport mon (input valid, input ready, input stable_key, input mode_request_valid,
		input mode_request, input pair_event, input reboot_request, input led_on,
		input input_armed);
endinterface

interface lkq_cfg_if import lkq_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/lkq_cfg_regs.sv =====
// Configuration register file for the keypad qualifier timings.
module lkq_cfg_regs import lkq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lkq_cfg_if.sink   cfg,
	output lkq_cfg_t  regs
);

	lkq_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_time     <= RST_DEBOUNCE;
			regs_q.release_arm_time  <= RST_RELEASE_ARM;
			regs_q.pair_hold_time    <= RST_PAIR_HOLD;
			regs_q.reboot_delay_time <= RST_REBOOT_DELAY;
			regs_q.blink_period      <= RST_BLINK_PERIOD;
		end else if (cfg.valid) begin
			// unknown indexes drop silently
			case (lkq_cfg_idx_t'(cfg.index))
				CFG_DEBOUNCE:     regs_q.debounce_time     <= cfg.data;
				CFG_RELEASE_ARM:  regs_q.release_arm_time  <= cfg.data;
				CFG_PAIR_HOLD:    regs_q.pair_hold_time    <= cfg.data;
				CFG_REBOOT_DELAY: regs_q.reboot_delay_time <= cfg.data;
				CFG_BLINK_PERIOD: regs_q.blink_period      <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/lkq_front.sv =====
// Front stage: take a sample, decode the ladder key and trim the timestamp.
module lkq_front import lkq_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lkq_in_if.sink               samp,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [KEY_W-1:0]     push_key,
	output logic [MODE_W-1:0]    push_mode,
	output logic [TIME_BITS-1:0] push_time
);

	logic                 valid_s1;
	logic [KEY_W-1:0]     key_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic                 take;

	assign samp.ready = !valid_s1 || push_ready;
	assign take       = samp.valid && samp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_s1  <= lkq_decode(samp.adc_sample);
			mode_s1 <= samp.current_mode;
			time_s1 <= samp.now_us[TIME_BITS-1:0];
		end
	end

	assign push_valid = valid_s1;
	assign push_key   = key_s1;
	assign push_mode  = mode_s1;
	assign push_time  = time_s1;

endmodule

// ===== sv/lkq_queue.sv =====
// Two-entry queue between the decode front and the qualifier back.
module lkq_queue import lkq_pkg::*; #(
	parameter int W = 70
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sv/lkq_back.sv =====
// Back stage: arming, debounce, press qualification, pair hold, reboot and LED.
module lkq_back import lkq_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lkq_cfg_t             cfg_regs,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [KEY_W-1:0]     q_key,
	input  logic [MODE_W-1:0]    q_mode,
	input  logic [TIME_BITS-1:0] q_time,
	lkq_out_if.source            res
);

	typedef logic [TIME_BITS-1:0] tm_t;

	// qualifier state
	logic [KEY_W-1:0] cand_q, deb_q;
	tm_t              cstart_q, rstart_q, pstart_q, rtime_q, blast_q;
	logic             armed_q, rsv_q, need_q, psv_q, pdone_q, pend_q, led_q;
	logic [3:0]       phase_q;

	logic [KEY_W-1:0] cand_n, deb_n;
	tm_t              cstart_n, rstart_n, pstart_n, rtime_n, blast_n;
	logic             armed_n, rsv_n, need_n, psv_n, pdone_n, pend_n, led_n;
	logic [3:0]       phase_n;

	// result register
	logic              out_valid_q;
	logic [KEY_W-1:0]  key_out_q;
	logic              mreq_valid_q;
	logic [MODE_W-1:0] mreq_q;
	logic              pevent_q, reboot_q, led_out_q, armed_out_q;

	logic              fire;
	logic              rel_ok, cand_ok, pair_ok, blink_ok, pair_new;
	logic              mreq_v, pevent, reboot;
	logic [MODE_W-1:0] mreq;
	logic [TIME_BITS:0] rb_sum;
	logic [MODE_W-1:0] pulses;
	logic [3:0]        pulses2;
	logic              even, fast;

	assign pop_ready = !out_valid_q || res.ready;
	assign fire      = pop_valid && pop_ready;

	// elapsed-time checks, all against pre-item state
	always_comb begin
		rel_ok   = tm_t'(q_time - rstart_q) >= tm_t'(cfg_regs.release_arm_time);
		cand_ok  = tm_t'(q_time - cstart_q) >= tm_t'(cfg_regs.debounce_time);
		blink_ok = tm_t'(q_time - blast_q)  >= tm_t'(cfg_regs.blink_period);
		rb_sum   = {1'b0, q_time} + (TIME_BITS + 1)'(cfg_regs.reboot_delay_time);
	end

	always_comb begin
		cand_n   = cand_q;
		deb_n    = deb_q;
		cstart_n = cstart_q;
		rstart_n = rstart_q;
		pstart_n = pstart_q;
		rtime_n  = rtime_q;
		blast_n  = blast_q;
		armed_n  = armed_q;
		rsv_n    = rsv_q;
		need_n   = need_q;
		psv_n    = psv_q;
		pdone_n  = pdone_q;
		pend_n   = pend_q;
		led_n    = led_q;
		phase_n  = phase_q;
		mreq_v   = 1'b0;
		mreq     = '0;
		pevent   = 1'b0;
		pair_new = 1'b0;
		pair_ok  = 1'b0;
		reboot   = 1'b0;
		pulses   = '0;
		pulses2  = '0;
		even     = 1'b0;
		fast     = 1'b0;

		if (!armed_q) begin
			// release guard: need an unbroken stretch of no key
			if (q_key == KEY_NONE) begin
				if (!rsv_q) begin
					rstart_n = q_time;
					rsv_n    = 1'b1;
				end else if (rel_ok) begin
					armed_n  = 1'b1;
					need_n   = 1'b0;
					cand_n   = KEY_NONE;
					deb_n    = KEY_NONE;
					cstart_n = q_time;
				end
			end else begin
				rsv_n = 1'b0;
			end
		end else begin
			if (q_key != cand_q) begin
				cand_n   = q_key;
				cstart_n = q_time;
			end else if (q_key != deb_q && cand_ok) begin
				deb_n = q_key;
				if (q_key == KEY_NONE) begin
					need_n  = 1'b0;
					psv_n   = 1'b0;
					pdone_n = 1'b0;
				end else if (!need_q) begin
					need_n = 1'b1;
					if (q_key == KEY_PAIR) begin
						pstart_n = q_time;
						psv_n    = 1'b1;
						pdone_n  = 1'b0;
						pair_new = 1'b1;
					end else begin
						mreq_v = 1'b1;
						mreq   = q_key - KEY_MODE_BASE;
					end
				end
			end
			// a hold that starts on this item has zero elapsed time
			pair_ok = pair_new ? (cfg_regs.pair_hold_time == '0)
				: (tm_t'(q_time - pstart_q) >= tm_t'(cfg_regs.pair_hold_time));
			if (deb_n == KEY_PAIR && psv_n && !pdone_n && pair_ok) begin
				pdone_n = 1'b1;
				pevent  = 1'b1;
				rtime_n = rb_sum[TIME_BITS-1:0];
				pend_n  = 1'b1;
			end
			// fresh schedule: now reaches now+delay only for zero delay or a wrap
			if (pevent) begin
				reboot = (cfg_regs.reboot_delay_time == '0) || rb_sum[TIME_BITS];
			end else begin
				reboot = pend_q && (q_time >= rtime_q);
			end
		end

		if (blink_ok) begin
			blast_n = q_time;
			phase_n = phase_q + 4'd1;
			even    = !phase_n[0];
			fast    = pend_n || (deb_n == KEY_PAIR);
			pulses  = (q_mode < MODE_COUNT) ? q_mode + 3'd1 : 3'd1;
			pulses2 = {pulses, 1'b0};
			led_n   = fast ? even : (even && (phase_n < pulses2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= KEY_NONE;
			deb_q    <= KEY_NONE;
			cstart_q <= '0;
			rstart_q <= '0;
			pstart_q <= '0;
			rtime_q  <= '0;
			blast_q  <= '0;
			armed_q  <= 1'b0;
			rsv_q    <= 1'b0;
			need_q   <= 1'b1;
			psv_q    <= 1'b0;
			pdone_q  <= 1'b0;
			pend_q   <= 1'b0;
			led_q    <= 1'b0;
			phase_q  <= '0;
		end else if (fire) begin
			cand_q   <= cand_n;
			deb_q    <= deb_n;
			cstart_q <= cstart_n;
			rstart_q <= rstart_n;
			pstart_q <= pstart_n;
			rtime_q  <= rtime_n;
			blast_q  <= blast_n;
			armed_q  <= armed_n;
			rsv_q    <= rsv_n;
			need_q   <= need_n;
			psv_q    <= psv_n;
			pdone_q  <= pdone_n;
			pend_q   <= pend_n;
			led_q    <= led_n;
			phase_q  <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			key_out_q    <= deb_n;
			mreq_valid_q <= mreq_v;
			mreq_q       <= mreq;
			pevent_q     <= pevent;
			reboot_q     <= reboot;
			led_out_q    <= led_n;
			armed_out_q  <= armed_n;
		end
	end

	assign res.valid              = out_valid_q;
	assign res.stable_key         = key_out_q;
	assign res.mode_request_valid = mreq_valid_q;
	assign res.mode_request       = mreq_q;
	assign res.pair_event         = pevent_q;
	assign res.reboot_request     = reboot_q;
	assign res.led_on             = led_out_q;
	assign res.input_armed        = armed_out_q;

endmodule

// ===== sv/ladder_keypad_qualifier.sv =====
// Top level of the resistor-ladder keypad qualifier.
//
//  channel | dir | handshake      | carries
//  --------+-----+----------------+---------------------------------------------
//  samp    | in  | valid/ready    | adc_sample, now_us, current_mode
//  res     | out | valid/ready    | stable_key, mode request, pair, reboot, LED
//  cfg     | in  | valid/ready    | index, data (timing registers, always ready)
//
// One sample is taken every cycle unless the decode register is full and the
// queue cannot take its sample; a result passes the decode register, a queue
// entry, then the qualifier update into the result register. Qualifier state
// updates as each entry is taken, so consecutive samples never wait on each
// other. A stalled result parks in the result register while a two-entry
// queue keeps the decode side flowing. Reset sets initial state, default timings.
module ladder_keypad_qualifier import lkq_pkg::*; #(
	parameter int TIME_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	lkq_in_if.sink     samp,
	lkq_out_if.source  res,
	lkq_cfg_if.sink    cfg
);

	localparam int QW = KEY_W + MODE_W + TIME_BITS;

	lkq_cfg_t             cfg_regs;
	logic                 push_valid, push_ready, pop_valid, pop_ready;
	logic [KEY_W-1:0]     push_key, q_key;
	logic [MODE_W-1:0]    push_mode, q_mode;
	logic [TIME_BITS-1:0] push_time, q_time;
	logic [QW-1:0]        push_data, pop_data;

	lkq_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	lkq_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp       (samp),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_key   (push_key),
		.push_mode  (push_mode),
		.push_time  (push_time)
	);

	assign push_data = {push_key, push_mode, push_time};

	lkq_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {q_key, q_mode, q_time} = pop_data;

	lkq_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_regs),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.q_key     (q_key),
		.q_mode    (q_mode),
		.q_time    (q_time),
		.res       (res)
	);

endmodule

// ===== sv/lkq_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module lkq_checker import lkq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [KEY_W-1:0]  stable_key,
	input logic              mode_request_valid,
	input logic [MODE_W-1:0] mode_request,
	input logic              pair_event,
	input logic              reboot_request,
	input logic              input_armed
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a mode request names the stable mode key
	a_mreq_key: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && mode_request_valid |->
			stable_key >= KEY_MODE_BASE && stable_key <= 3'd6 &&
			mode_request == stable_key - KEY_MODE_BASE)
		else $error("mode request does not match stable key");

	// a pair latch happens only with the pair key stable
	a_pair_key: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pair_event |-> stable_key == KEY_PAIR)
		else $error("pair event without pair key");

	// no press, pair or reboot before arming
	a_armed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (mode_request_valid || pair_event || reboot_request)
			|-> input_armed)
		else $error("key action reported while unarmed");

endmodule

bind ladder_keypad_qualifier lkq_checker u_lkq_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.stable_key         (res.stable_key),
	.mode_request_valid (res.mode_request_valid),
	.mode_request       (res.mode_request),
	.pair_event         (res.pair_event),
	.reboot_request     (res.reboot_request),
	.input_armed        (res.input_armed)
);
